### sv/hcmf_pkg.sv
// ----------------------------------------------------------------------------
// hcmf_pkg
// Shared types, degree tables and angle constants for the heading circular
// mean filter.
// ----------------------------------------------------------------------------
`default_nettype none

package hcmf_pkg;

  // input item: raw heading and target direction, whole degrees
  typedef struct packed {
    logic [8:0] heading_deg;
    logic [8:0] target_deg;
  } sample_t;

  // result item: mean heading and target relative to it
  typedef struct packed {
    logic signed [8:0] mean_heading_deg;
    logic [8:0]        relative_deg;
  } result_t;

  // degree constants
  localparam logic [8:0] DEG_QUARTER = 9'd90;
  localparam logic [8:0] DEG_HALF    = 9'd180;
  localparam logic [8:0] DEG_THREE_Q = 9'd270;
  localparam logic [8:0] DEG_FULL    = 9'd360;

  // angle accumulator: degrees with 16 fraction bits
  localparam int ANGLE_FRAC = 16;
  localparam int Z_W        = 27;
  localparam logic signed [Z_W-1:0] ANGLE_HALF    = 27'sd11796480;
  localparam logic signed [Z_W-1:0] ANGLE_QUARTER = 27'sd5898240;
  localparam logic [Z_W-ANGLE_FRAC-1:0] MEAN_LIMIT = 11'd180;

  // number of entries in the arctangent table
  localparam int ARC_DEPTH = 24;
  localparam int ARC_IDX_W = 5;

  // sine of 0..90 degrees, Q1.14
  localparam logic [14:0] QUARTER_SINE [91] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // atan(2^-i) in degrees with 16 fraction bits
  localparam logic [21:0] ARC_STEP [ARC_DEPTH] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

  // sine of a whole degree 0..359 from the quarter-wave table
  function automatic logic signed [15:0] table_sine(input logic [8:0] d);
    logic [8:0]        idx;
    logic              neg;
    logic signed [15:0] mag;
    if (d <= DEG_QUARTER) begin
      idx = d;
      neg = 1'b0;
    end else if (d <= DEG_HALF) begin
      idx = DEG_HALF - d;
      neg = 1'b0;
    end else if (d <= DEG_THREE_Q) begin
      idx = d - DEG_HALF;
      neg = 1'b1;
    end else begin
      idx = DEG_FULL - d;
      neg = 1'b1;
    end
    mag = signed'({1'b0, QUARTER_SINE[idx[6:0]]});
    return neg ? -mag : mag;
  endfunction

endpackage

`default_nettype wire

### sv/hcmf_cordic.sv
// ----------------------------------------------------------------------------
// hcmf_cordic
// Vectoring CORDIC computing atan2(y, x) in whole degrees, truncated toward
// zero and clamped to -180..180, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hcmf_cordic #(
  parameter int SUM_W = 21,
  parameter int STEPS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [SUM_W-1:0] x_in,
  input  wire logic signed [SUM_W-1:0] y_in,
  output logic                         done,
  output logic signed [8:0]            deg
);
  import hcmf_pkg::*;

  // headroom for the CORDIC gain
  localparam int CW    = SUM_W + 2;
  localparam int CNT_W = $clog2(STEPS);
  localparam int Q_W   = Z_W - ANGLE_FRAC;

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_RUN  = 3'b010,
    C_CONV = 3'b100
  } cstate_t;

  cstate_t                  state, state_next;
  logic signed [CW-1:0]     x, y;
  logic signed [Z_W-1:0]    z;
  logic [CNT_W-1:0]         cnt;
  logic signed [CW-1:0]     x0, y0;
  logic signed [CW-1:0]     dx, dy;
  logic signed [Z_W-1:0]    arc_z;
  logic [Z_W-1:0]           z_mag;
  logic [Q_W-1:0]           q, q_lim;

  assign x0    = CW'(x_in);
  assign y0    = CW'(y_in);
  assign dx    = y >>> cnt;
  assign dy    = x >>> cnt;
  assign arc_z = signed'(Z_W'(ARC_STEP[ARC_IDX_W'(cnt)]));

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      C_IDLE: begin
        if (start) begin
          state_next = (y0 == '0 || x0 == '0) ? C_CONV : C_RUN;
        end
      end
      C_RUN: begin
        if (cnt == CNT_W'(STEPS - 1)) state_next = C_CONV;
      end
      C_CONV:  state_next = C_IDLE;
      default: state_next = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= C_IDLE;
    else     state <= state_next;
  end

  // datapath: setup with axis cases, then one rotation per cycle
  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        cnt <= '0;
        x   <= x0;
        y   <= y0;
        if (y0 == '0) begin
          z <= (x0 < 0) ? ANGLE_HALF : '0;
        end else if (x0 == '0) begin
          z <= (y0 > 0) ? ANGLE_QUARTER : -ANGLE_QUARTER;
        end else if (x0 < 0) begin
          // turn by half a circle first
          z <= (y0 > 0) ? ANGLE_HALF : -ANGLE_HALF;
          x <= -x0;
          y <= -y0;
        end else begin
          z <= '0;
        end
      end
      C_RUN: begin
        cnt <= cnt + 1'b1;
        if (y > 0) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + arc_z;
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - arc_z;
        end
      end
      default: ;
    endcase
  end

  // truncate toward zero to whole degrees and clamp
  assign z_mag = (z < 0) ? unsigned'(-z) : unsigned'(z);
  assign q     = z_mag[Z_W-1:ANGLE_FRAC];
  assign q_lim = (q > MEAN_LIMIT) ? MEAN_LIMIT : q;
  assign deg   = (z < 0) ? -signed'(q_lim[8:0]) : signed'(q_lim[8:0]);
  assign done  = (state == C_CONV);

endmodule

`default_nettype wire

### sv/heading_circular_mean_filter_unit.sv
// ----------------------------------------------------------------------------
// heading_circular_mean_filter_unit
// Moving circular mean of compass headings over a sample window, and the
// direction to a target relative to that mean.
// ----------------------------------------------------------------------------
// sample channel: sample_valid / sample_stall / sample carry one heading and
//   one target direction per item; sample_stall is high from accept until
//   the result of that item has been loaded into the output register
// result channel: result_valid / result_stall / result carry the mean heading
//   (-180..180) and target minus mean (0..359), one item per sample
// sequence: after accept the window and sums update (S_LOAD), the CORDIC
//   starts (S_START) and is awaited (S_WAIT), then S_DONE loads the result;
//   the CORDIC does one rotation per cycle, none if either sum is zero
// items: one at a time; the next is taken after the result is loaded
// stall: the held result stays put; the next item is still taken and worked
//   on, then waits with sample_stall high until the output register frees
// reset: rst (synchronous, active high) clears the window and running sums
//   to zero, so the first averages include those zero samples
// ----------------------------------------------------------------------------
`default_nettype none

module heading_circular_mean_filter_unit #(
  parameter int WINDOW_LENGTH = 20,
  parameter int CORDIC_STEPS  = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              sample_valid,
  output logic                   sample_stall,
  input  wire hcmf_pkg::sample_t sample,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output hcmf_pkg::result_t      result
);
  import hcmf_pkg::*;

  localparam int SUM_W = $clog2(WINDOW_LENGTH + 1) + 16;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_START = 5'b00100,
    S_WAIT  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                   state, state_next;
  logic [8:0]               heading, target;
  logic signed [8:0]        mean;
  logic signed [15:0]       sin_win [WINDOW_LENGTH];
  logic signed [15:0]       cos_win [WINDOW_LENGTH];
  logic signed [SUM_W-1:0]  sin_sum, cos_sum;
  logic signed [15:0]       sin_new, cos_new;
  logic [9:0]               cos_idx_w;
  logic [8:0]               cos_idx;
  logic                     cordic_done;
  logic signed [8:0]        cordic_deg;
  logic signed [10:0]       rel_raw;
  logic signed [10:0]       rel;
  logic                     sample_take, result_free;

  assign sample_take  = sample_valid && (state == S_IDLE);
  assign sample_stall = (state != S_IDLE);
  assign result_free  = !result_valid || !result_stall;

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (sample_valid) state_next = S_LOAD;
      S_LOAD:  state_next = S_START;
      S_START: state_next = S_WAIT;
      S_WAIT:  if (cordic_done) state_next = S_DONE;
      S_DONE:  if (result_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // capture inputs, folding 360..511 down once
  always_ff @(posedge clk) begin
    if (sample_take) begin
      heading <= (sample.heading_deg >= DEG_FULL) ? sample.heading_deg - DEG_FULL
                                                  : sample.heading_deg;
      target  <= (sample.target_deg >= DEG_FULL) ? sample.target_deg - DEG_FULL
                                                 : sample.target_deg;
    end
  end

  // sine and cosine lookups
  assign cos_idx_w = {1'b0, heading} + {1'b0, DEG_QUARTER};
  assign cos_idx   = (cos_idx_w >= {1'b0, DEG_FULL}) ? 9'(cos_idx_w - {1'b0, DEG_FULL})
                                                     : cos_idx_w[8:0];
  assign sin_new   = table_sine(heading);
  assign cos_new   = table_sine(cos_idx);

  // sample window and running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      sin_sum <= '0;
      cos_sum <= '0;
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        sin_win[i] <= '0;
        cos_win[i] <= '0;
      end
    end else if (state == S_LOAD) begin
      sin_sum <= sin_sum + SUM_W'(sin_new) - SUM_W'(sin_win[WINDOW_LENGTH-1]);
      cos_sum <= cos_sum + SUM_W'(cos_new) - SUM_W'(cos_win[WINDOW_LENGTH-1]);
      for (int i = WINDOW_LENGTH - 1; i > 0; i--) begin
        sin_win[i] <= sin_win[i-1];
        cos_win[i] <= cos_win[i-1];
      end
      sin_win[0] <= sin_new;
      cos_win[0] <= cos_new;
    end
  end

  // atan2 of the sums
  hcmf_cordic #(
    .SUM_W (SUM_W),
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_START),
    .x_in  (cos_sum),
    .y_in  (sin_sum),
    .done  (cordic_done),
    .deg   (cordic_deg)
  );

  always_ff @(posedge clk) begin
    if (state == S_WAIT && cordic_done) mean <= cordic_deg;
  end

  // target minus mean, wrapped once
  assign rel_raw = signed'({2'b00, target}) - 11'(mean);
  always_comb begin
    if (rel_raw < 0)                             rel = rel_raw + 11'sd360;
    else if (rel_raw >= signed'({2'b00, DEG_FULL})) rel = rel_raw - 11'sd360;
    else                                         rel = rel_raw;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_DONE && result_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && result_free) begin
      result.mean_heading_deg <= mean;
      result.relative_deg     <= rel[8:0];
    end
  end

endmodule

`default_nettype wire

### tb/sv/tb_heading_circular_mean_filter_unit.sv
// ----------------------------------------------------------------------------
// tb_heading_circular_mean_filter_unit
// Self-checking bench for the heading circular mean filter. A table of
// directed items (empty window, cancelling sums, axis cases, inputs above
// 359) is followed by random heading streams: full-range noise, slow drift
// and near-opposite pairs that keep the running sums close to zero. Fixed
// directed rows are checked against typed-in results, the rest against a
// windowed-sum and CORDIC model, with random sample idles and result stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_heading_circular_mean_filter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import hcmf_pkg::*;

  localparam int WIN        = 20;
  localparam int STEPS      = 16;
  localparam int ANGLE_UNIT = 65536;
  localparam int RANDOM_ITEMS = 1750;

  // sine of 0..90 degrees, Q1.14
  localparam int QSIN [91] = '{
    0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
    2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
    5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
    8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384
  };

  // atan(2^-i) in degrees with 16 fraction bits
  localparam int ATAN_DEG [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef enum int {MODE_NOISE, MODE_DRIFT, MODE_OPPOSED} heading_mode_e;

  // one directed row: result typed in only where fixed is set
  typedef struct packed {
    logic [8:0]        heading;
    logic [8:0]        target;
    logic              fixed;
    logic signed [8:0] mean;
    logic [8:0]        rel;
  } directed_row_t;

  localparam directed_row_t DIRECTED [24] = '{
    // empty window plus one north sample
    '{9'd0,   9'd0,   1'b1, 9'sd0,   9'd0},
    // north and south cancel: both sums zero
    '{9'd180, 9'd359, 1'b1, 9'sd0,   9'd359},
    // sine sum zero, cosine sum negative
    '{9'd180, 9'd0,   1'b1, 9'sd180, 9'd180},
    '{9'd0,   9'd90,  1'b1, 9'sd0,   9'd90},
    // cosine sum zero, sine sum positive
    '{9'd90,  9'd0,   1'b1, 9'sd90,  9'd270},
    '{9'd270, 9'd359, 1'b1, 9'sd0,   9'd359},
    // cosine sum zero, sine sum negative; relative wraps down
    '{9'd270, 9'd359, 1'b1, -9'sd90, 9'd89},
    // both fields above 359
    '{9'd450, 9'd511, 1'b1, 9'sd0,   9'd151},
    '{9'd360, 9'd360, 1'b1, 9'sd0,   9'd0},
    '{9'd511, 9'd180, 1'b0, 9'sd0,   9'd0},
    '{9'd135, 9'd0,   1'b0, 9'sd0,   9'd0},
    '{9'd225, 9'd256, 1'b0, 9'sd0,   9'd0},
    '{9'd315, 9'd359, 1'b0, 9'sd0,   9'd0},
    '{9'd45,  9'd1,   1'b0, 9'sd0,   9'd0},
    '{9'd359, 9'd300, 1'b0, 9'sd0,   9'd0},
    '{9'd1,   9'd179, 1'b0, 9'sd0,   9'd0},
    '{9'd179, 9'd181, 1'b0, 9'sd0,   9'd0},
    '{9'd181, 9'd255, 1'b0, 9'sd0,   9'd0},
    '{9'd89,  9'd128, 1'b0, 9'sd0,   9'd0},
    '{9'd91,  9'd64,  1'b0, 9'sd0,   9'd0},
    '{9'd269, 9'd383, 1'b0, 9'sd0,   9'd0},
    '{9'd271, 9'd320, 1'b0, 9'sd0,   9'd0},
    '{9'd256, 9'd0,   1'b0, 9'sd0,   9'd0},
    '{9'd300, 9'd511, 1'b0, 9'sd0,   9'd0}
  };

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    sample_valid = 1'b0;
  logic    sample_stall;
  sample_t sample = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  bit      idle_on = 1'b1;
  int      mismatch_count = 0;
  result_t pending_results [$];

  // model state: heading window and running sums, zero after reset
  int      sine_hist [WIN];
  int      cosine_hist [WIN];
  longint  sine_acc = 0;
  longint  cosine_acc = 0;

  heading_circular_mean_filter_unit #(
    .WINDOW_LENGTH(WIN),
    .CORDIC_STEPS (STEPS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample      (sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  always #5 clk = ~clk;

  initial begin
    foreach (sine_hist[i]) begin
      sine_hist[i]   = 0;
      cosine_hist[i] = 0;
    end
  end

  // sine of a whole degree, any non-negative angle
  function automatic int degree_sine(int d);
    d = d % 360;
    if (d <= 90) return QSIN[d];
    if (d <= 180) return QSIN[180 - d];
    if (d <= 270) return -QSIN[d - 180];
    return -QSIN[360 - d];
  endfunction

  // atan2(y, x) in whole degrees, truncated toward zero
  function automatic int vector_angle(longint x, longint y);
    longint z;
    longint dx;
    longint dy;
    longint whole;
    z = 0;
    if (y == 0) return (x < 0) ? 180 : 0;
    if (x == 0) return (y > 0) ? 90 : -90;
    // left half plane: rotate by 180 first
    if (x < 0) begin
      z = (y > 0) ? 180 * ANGLE_UNIT : -180 * ANGLE_UNIT;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_DEG[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_DEG[i];
      end
    end
    whole = z / ANGLE_UNIT;
    if (whole > 180) whole = 180;
    if (whole < -180) whole = -180;
    return int'(whole);
  endfunction

  // push one heading into the window and return the filtered result
  function automatic result_t filter_step(sample_t item);
    int      h;
    int      t;
    int      sn;
    int      cs;
    int      mean;
    int      rel;
    result_t r;
    h = item.heading_deg;
    t = item.target_deg;
    if (h >= 360) h -= 360;
    if (t >= 360) t -= 360;
    sn = degree_sine(h);
    cs = degree_sine(h + 90);
    sine_acc   += sn - sine_hist[WIN-1];
    cosine_acc += cs - cosine_hist[WIN-1];
    for (int i = WIN - 1; i > 0; i--) begin
      sine_hist[i]   = sine_hist[i-1];
      cosine_hist[i] = cosine_hist[i-1];
    end
    sine_hist[0]   = sn;
    cosine_hist[0] = cs;
    mean = vector_angle(cosine_acc, sine_acc);
    rel = t - mean;
    if (rel < 0) rel += 360;
    else if (rel >= 360) rel -= 360;
    r.mean_heading_deg = mean[8:0];
    r.relative_deg     = rel[8:0];
    return r;
  endfunction

  // present one item, wait for acceptance, record its expected result
  task automatic send_item(input sample_t item, input logic fixed, input result_t want);
    result_t predicted;
    while (idle_on && $urandom_range(99) < 9) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= item;
    do @(posedge clk); while (sample_stall);
    predicted = filter_step(item);
    pending_results.push_back(fixed ? want : predicted);
  endtask

  // stop sending until every expected result has come back
  task automatic drain_results();
    sample_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // random heading streams in segments of one flavor each
  task automatic run_random(input int count);
    heading_mode_e mode;
    int            left;
    int            base;
    int            h;
    sample_t       item;
    result_t       none;
    left = 0;
    base = 0;
    mode = MODE_NOISE;
    none = '0;
    for (int k = 0; k < count; k++) begin
      if (left == 0) begin
        mode = heading_mode_e'($urandom_range(2));
        left = $urandom_range(40, 5);
        base = $urandom_range(359);
      end
      left--;
      // quiet stretch with no idles on either side
      idle_on = !(k >= 600 && k < 900);
      case (mode)
        MODE_NOISE: begin
          h = $urandom_range(511);
        end
        MODE_DRIFT: begin
          base = (base + int'($urandom_range(20)) - 10 + 360) % 360;
          h = base;
        end
        default: begin
          // near-opposite pairs keep the sums small
          h = (k % 2) ? base : (base + 179 + int'($urandom_range(2))) % 360;
        end
      endcase
      if (mode != MODE_NOISE && h < 152 && $urandom_range(7) == 0) h += 360;
      item.heading_deg = h[8:0];
      item.target_deg  = 9'($urandom_range(511));
      send_item(item, 1'b0, none);
    end
  endtask

  // stimulus
  initial begin
    result_t want;
    sample_t item;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED[i]) begin
      item.heading_deg      = DIRECTED[i].heading;
      item.target_deg       = DIRECTED[i].target;
      want.mean_heading_deg = DIRECTED[i].mean;
      want.relative_deg     = DIRECTED[i].rel;
      send_item(item, DIRECTED[i].fixed, want);
    end
    drain_results();
    run_random(RANDOM_ITEMS);
    drain_results();
    repeat (STEPS + 20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("heading_circular_mean_filter_unit: match");
    end else begin
      $display("heading_circular_mean_filter_unit: mismatch");
    end
    $finish;
  end

  // result side stalls at random
  always @(posedge clk) begin
    result_stall <= idle_on && ($urandom_range(99) < 9);
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $error("result item with no expected item pending: mean %0d rel %0d",
               $signed(result.mean_heading_deg), result.relative_deg);
      end else begin
        want = pending_results.pop_front();
        if (result.mean_heading_deg !== want.mean_heading_deg) begin
          mismatch_count++;
          $error("mean_heading_deg expected %0d got %0d",
                 $signed(want.mean_heading_deg), $signed(result.mean_heading_deg));
        end
        if (result.relative_deg !== want.relative_deg) begin
          mismatch_count++;
          $error("relative_deg expected %0d got %0d",
                 want.relative_deg, result.relative_deg);
        end
      end
    end
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("heading_circular_mean_filter_unit: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
